FILE: rtl/core/spcs_pkg.sv
// Shared constants, types and controller state codes for the sprite priority sorter.
`default_nettype none

package spcs_pkg;

	localparam int MAX_SPRITES = 64;
	localparam int STORE_DEPTH = 64;
	localparam int CAPACITY    = (MAX_SPRITES < STORE_DEPTH) ? MAX_SPRITES : STORE_DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int WORD_W      = 16;
	localparam int SLOT_W      = 6;
	localparam int RANK_W      = ADDR_W;
	localparam int PRIO_W      = 2;
	localparam int PRIO_LSB    = 10;
	localparam int NUM_BUCKETS = 4;
	localparam int ENTRY_W     = 4 * WORD_W + RANK_W;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_SHOW
	} spcs_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic read;
		logic advance;
	} spcs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic final_entry;
	} spcs_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/spcs_ctrl.sv
// Controller state machine: batch loading, read issue and result transfer.
`default_nettype none

module spcs_ctrl
	import spcs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      last_sprite,
	input  wire logic      out_stall,
	input  wire spcs_sts_t sts,
	output      logic      in_stall,
	output      logic      out_valid,
	output      spcs_cmd_t cmd
);

	spcs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && last_sprite) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_SHOW;
			end
			ST_SHOW: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.advance = 1'b1;
					state_d     = sts.final_entry ? ST_LOAD : ST_READ;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result is shown");

	a_read_before_show: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |=> out_valid)
		else $error("read not followed by result");

	a_final_returns_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.advance && sts.final_entry) |=> !in_stall)
		else $error("batch end did not reopen input");

endmodule

`default_nettype wire

FILE: rtl/core/spcs_dp.sv
// Datapath: entry memory, bucket counters, read index and slot computation.
`default_nettype none

module spcs_dp
	import spcs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic                cfg_wr_data,
	input  wire logic [WORD_W-1:0]   attr_word0,
	input  wire logic [WORD_W-1:0]   attr_word1,
	input  wire logic [WORD_W-1:0]   attr_word2,
	input  wire logic [WORD_W-1:0]   attr_fill,
	input  wire spcs_cmd_t           cmd,
	output      spcs_sts_t           sts,
	output      logic [SLOT_W-1:0]   slot_index,
	output      logic [WORD_W-1:0]   out_word0,
	output      logic [WORD_W-1:0]   out_word1,
	output      logic [WORD_W-1:0]   out_word2,
	output      logic [WORD_W-1:0]   out_fill
);

	logic [ENTRY_W-1:0] mem [STORE_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   bucket_q [NUM_BUCKETS];
	logic [ADDR_W-1:0]  rd_idx_q;
	logic               sort_en_q;

	logic [PRIO_W-1:0]  in_prio;
	logic [PRIO_W-1:0]  rd_prio;
	logic [RANK_W-1:0]  rd_rank;
	logic [SLOT_W-1:0]  offset [NUM_BUCKETS];
	logic               room;
	logic               store;

	assign in_prio = attr_word2[PRIO_LSB +: PRIO_W];
	assign room    = count_q < CNT_W'(CAPACITY);
	assign store   = cmd.accept && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			sort_en_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			mem[count_q[ADDR_W-1:0]] <= {bucket_q[in_prio][RANK_W-1:0],
				attr_fill, attr_word2, attr_word1, attr_word0};
		end
		if (cmd.read) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_idx_q <= '0;
			for (int b = 0; b < NUM_BUCKETS; b++) begin
				bucket_q[b] <= '0;
			end
		end else if (cmd.advance && sts.final_entry) begin
			// batch done: clear counters for the next one
			count_q  <= '0;
			rd_idx_q <= '0;
			for (int b = 0; b < NUM_BUCKETS; b++) begin
				bucket_q[b] <= '0;
			end
		end else begin
			if (cmd.advance) begin
				rd_idx_q <= rd_idx_q + ADDR_W'(1);
			end
			if (store) begin
				count_q          <= count_q + CNT_W'(1);
				bucket_q[in_prio] <= bucket_q[in_prio] + CNT_W'(1);
			end
		end
	end

	// exclusive prefix sum of lower-priority counts, kept modulo the slot range
	always_comb begin
		offset[0] = '0;
		for (int b = 1; b < NUM_BUCKETS; b++) begin
			offset[b] = offset[b-1] + bucket_q[b-1][SLOT_W-1:0];
		end
	end

	assign rd_prio = rd_data_q[2*WORD_W + PRIO_LSB +: PRIO_W];
	assign rd_rank = rd_data_q[4*WORD_W +: RANK_W];

	assign sts.final_entry = ({1'b0, rd_idx_q} + CNT_W'(1)) == count_q;

	assign slot_index = sort_en_q ? (offset[rd_prio] + SLOT_W'(rd_rank))
	                              : SLOT_W'(rd_idx_q);
	assign out_word0  = rd_data_q[0 +: WORD_W];
	assign out_word1  = rd_data_q[WORD_W +: WORD_W];
	assign out_word2  = rd_data_q[2*WORD_W +: WORD_W];
	assign out_fill   = rd_data_q[3*WORD_W +: WORD_W];

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_read_within_batch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |-> ({1'b0, rd_idx_q} < count_q))
		else $error("read past stored entries");

	a_clear_after_batch: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.advance && sts.final_entry) |=> (count_q == '0 && rd_idx_q == '0))
		else $error("counters not cleared after batch");

endmodule

`default_nettype wire

FILE: rtl/core/sprite_priority_counting_sort.sv
// Top level of the stable four-bucket sprite priority sorter.
//
//  channel  direction  handshake             payload
//  input    in         in_valid / in_stall   attr_word0..2, attr_fill, last_sprite
//  output   out        out_valid / out_stall slot_index, out_word0..2, out_fill, last_out
//  config   in         cfg_wr_en             cfg_wr_data (sort_enable)
//
// While loading, input is never stalled; entries past capacity are dropped.
// After the entry marked last, each stored entry is read from memory, then shown
// until out_stall is low; input stays stalled meanwhile. The next entry is read only
// after the shown one is taken, through the single registered read port of the memory.
// Reset clears the counters, sort_enable and the controller; memory is not cleared.
`default_nettype none

module sprite_priority_counting_sort
	import spcs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic              cfg_wr_data,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic [WORD_W-1:0] attr_word0,
	input  wire logic [WORD_W-1:0] attr_word1,
	input  wire logic [WORD_W-1:0] attr_word2,
	input  wire logic [WORD_W-1:0] attr_fill,
	input  wire logic              last_sprite,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      logic [SLOT_W-1:0] slot_index,
	output      logic [WORD_W-1:0] out_word0,
	output      logic [WORD_W-1:0] out_word1,
	output      logic [WORD_W-1:0] out_word2,
	output      logic [WORD_W-1:0] out_fill,
	output      logic              last_out
);

	spcs_cmd_t cmd;
	spcs_sts_t sts;

	spcs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_sprite (last_sprite),
		.out_stall   (out_stall),
		.sts         (sts),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.cmd         (cmd)
	);

	spcs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.attr_word0  (attr_word0),
		.attr_word1  (attr_word1),
		.attr_word2  (attr_word2),
		.attr_fill   (attr_fill),
		.cmd         (cmd),
		.sts         (sts),
		.slot_index  (slot_index),
		.out_word0   (out_word0),
		.out_word1   (out_word1),
		.out_word2   (out_word2),
		.out_fill    (out_fill)
	);

	assign last_out = sts.final_entry;

endmodule

`default_nettype wire
